// ===== src/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg - signal pending dispatcher shared definitions
// Signal numbering limits, operation codes, stream item layouts and the
// per-step decision record that the scan step hands to the sequencer.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int MAX_SIGNAL  = 31;
    localparam int MIN_SIGNAL  = 1;
    localparam int KILL_SIGNAL = 9;
    localparam int STOP_SIGNAL = 19;
    localparam int SCAN_TOP    = (MAX_SIGNAL > 31) ? 31 : MAX_SIGNAL;

    localparam int SIG_W   = 5;
    localparam int NUM_SIG = 1 << SIG_W;

    // operation codes (tuser)
    localparam logic [2:0] ACT_POST    = 3'd0;
    localparam logic [2:0] ACT_SETACT  = 3'd1;
    localparam logic [2:0] ACT_MASK    = 3'd2;
    localparam logic [2:0] ACT_PENDING = 3'd3;
    localparam logic [2:0] ACT_DELIVER = 3'd4;
    localparam logic [2:0] ACT_HRET    = 3'd5;

    // action kinds
    localparam logic [1:0] DISP_DEFAULT = 2'd0;
    localparam logic [1:0] DISP_IGNORE  = 2'd1;
    localparam logic [1:0] DISP_HANDLER = 2'd2;

    // mask change modes
    localparam logic [1:0] HOW_BLOCK   = 2'd0;
    localparam logic [1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [1:0] HOW_SETMASK = 2'd2;

    localparam int ACT_W      = 3;
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 224;

    // declared high field first so that signo lands in the low bits
    typedef struct packed {
        logic [1:0]        mask_how;
        logic [31:0]       mask_value;
        logic [63:0]       restorer_addr;
        logic [63:0]       handler_addr;
        logic [1:0]        disposition;
        logic [15:0]       sender_pid;
        logic signed [31:0] code;
        logic [SIG_W-1:0]  signo;
    } t_item;

    typedef struct packed {
        logic [1:0]        old_disposition;
        logic [31:0]       set_out;
        logic [15:0]       info_pid;
        logic signed [31:0] info_code;
        logic [63:0]       return_addr;
        logic [63:0]       target_addr;
        logic [SIG_W-1:0]  deliver_signo;
        logic              delivered;
        logic [SIG_W-1:0]  kill_signo;
        logic              killed;
        logic              status;
    } t_result;

    localparam int ITEM_W = $bits(t_item);
    localparam int RES_W  = $bits(t_result);

    // outcome of examining one signal during a deliver scan
    typedef struct packed {
        logic clr_pend;
        logic kill;
        logic hit;
    } t_step;

    function automatic logic sig_ok(input logic [SIG_W-1:0] s);
        return (int'(s) >= MIN_SIGNAL) && (int'(s) <= MAX_SIGNAL);
    endfunction

endpackage

// ===== src/spd_act_tbl.sv =====
// ----------------------------------------------------------------------------
// spd_act_tbl - per-signal action table
// Action kinds live in flops for the one-entry-per-cycle scan; handler,
// restorer and handler mask live in a memory with a registered read and a
// valid bit per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module spd_act_tbl
    import spd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [SIG_W-1:0] i_wr_idx,
    input  logic [1:0]       i_wr_kind,
    input  logic [63:0]      i_wr_handler,
    input  logic [63:0]      i_wr_restorer,
    input  logic [31:0]      i_wr_mask,
    input  logic [SIG_W-1:0] i_kind_idx,
    output logic [1:0]       o_kind,
    input  logic             i_rd_en,
    input  logic [SIG_W-1:0] i_rd_idx,
    output logic [63:0]      o_rd_handler,
    output logic [63:0]      o_rd_restorer,
    output logic [31:0]      o_rd_mask
);

    logic [1:0]        r_kind [NUM_SIG];
    logic [NUM_SIG-1:0] r_valid;
    logic [63:0]       r_handler_mem [NUM_SIG];
    logic [63:0]       r_restorer_mem [NUM_SIG];
    logic [31:0]       r_mask_mem [NUM_SIG];
    logic [63:0]       r_rd_handler;
    logic [63:0]       r_rd_restorer;
    logic [31:0]       r_rd_mask;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < NUM_SIG; i++) begin
                r_kind[i] <= DISP_DEFAULT;
            end
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= 1'b1;
            r_kind[i_wr_idx]  <= i_wr_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_handler_mem[i_wr_idx]  <= i_wr_handler;
            r_restorer_mem[i_wr_idx] <= i_wr_restorer;
            r_mask_mem[i_wr_idx]     <= i_wr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_handler  <= r_handler_mem[i_rd_idx];
            r_rd_restorer <= r_restorer_mem[i_rd_idx];
            r_rd_mask     <= r_mask_mem[i_rd_idx];
            r_rd_valid    <= r_valid[i_rd_idx];
        end
    end

    assign o_kind        = r_kind[i_kind_idx];
    assign o_rd_handler  = r_rd_valid ? r_rd_handler  : '0;
    assign o_rd_restorer = r_rd_valid ? r_rd_restorer : '0;
    assign o_rd_mask     = r_rd_valid ? r_rd_mask     : '0;

endmodule

// ===== src/spd_info_tbl.sv =====
// ----------------------------------------------------------------------------
// spd_info_tbl - sender info store
// Reason code and sender id of the last post of each signal, one memory
// with a registered read port.
// ----------------------------------------------------------------------------
module spd_info_tbl
    import spd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [SIG_W-1:0]   i_wr_idx,
    input  logic signed [31:0] i_wr_code,
    input  logic [15:0]        i_wr_pid,
    input  logic               i_rd_en,
    input  logic [SIG_W-1:0]   i_rd_idx,
    output logic signed [31:0] o_rd_code,
    output logic [15:0]        o_rd_pid
);

    logic [47:0] r_mem [NUM_SIG];
    logic [47:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_pid, i_wr_code};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_code = signed'(r_rd_data[31:0]);
    assign o_rd_pid  = r_rd_data[47:32];

endmodule

// ===== src/spd_scan_step.sv =====
// ----------------------------------------------------------------------------
// spd_scan_step - deliver scan decision unit
// Judges one signal of the scan: consumed, terminating, skipped as blocked,
// or the handler signal that ends the scan.
// ----------------------------------------------------------------------------
module spd_scan_step
    import spd_pkg::*;
(
    input  logic [SIG_W-1:0] i_sig,
    input  logic [31:0]      i_pending,
    input  logic [31:0]      i_blocked,
    input  logic [1:0]       i_kind,
    output t_step            o_step
);

    logic w_forced;

    assign w_forced = (int'(i_sig) == KILL_SIGNAL) || (int'(i_sig) == STOP_SIGNAL);

    always_comb begin
        o_step = '0;
        if (i_pending[i_sig]) begin
            if (w_forced) begin
                o_step.clr_pend = 1'b1;
                o_step.kill     = 1'b1;
            end else if (!i_blocked[i_sig]) begin
                o_step.clr_pend = 1'b1;
                if (i_kind == DISP_HANDLER) begin
                    o_step.hit = 1'b1;
                end else if (i_kind != DISP_IGNORE) begin
                    o_step.kill = 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/signal_pending_dispatcher.sv =====
// ----------------------------------------------------------------------------
// signal_pending_dispatcher - per-process signal unit
// Pending and blocked sets, action table and sender info with post, set
// action, mask change, pending read, deliver and handler return operations.
// ----------------------------------------------------------------------------
// One operation is taken at a time and answered by exactly one result.
// Post, mask change, pending read, handler return and bad operation codes
// go from the execute state straight to the output state; set action passes
// through an extra lookup state because the old action comes out of the table
// through a registered read. Deliver walks the pending set one signal per
// cycle from the lowest number, through a single scan step unit, examining
// up to 31 signals, and adds a fetch state when a handler signal is found
// and its addresses, mask and sender info are fetched. The result sits in an
// output register, so the next operation can be taken while it waits.
module signal_pending_dispatcher
    import spd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // signo, code, sender_pid, disposition, handler_addr, restorer_addr,
    // mask_value, mask_how, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, killed, kill_signo, delivered, deliver_signo, target_addr,
    // return_addr, info_code, info_pid, set_out, old_disposition, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FETCH = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    t_item            r_item;
    logic [ACT_W-1:0] r_act;
    t_result          r_res, n_res;
    logic [31:0]      r_pending, n_pending;
    logic [31:0]      r_blocked, n_blocked;
    logic [SIG_W-1:0] r_cur, n_cur;
    logic             r_m_valid;
    t_result          r_m_data;

    logic               w_accept;
    logic               w_load;
    logic               w_act_wr;
    logic [SIG_W-1:0]   w_kind_idx;
    logic [1:0]         w_kind;
    logic               w_act_rd;
    logic [SIG_W-1:0]   w_rd_idx;
    logic [63:0]        w_rd_handler;
    logic [63:0]        w_rd_restorer;
    logic [31:0]        w_rd_mask;
    logic               w_info_wr;
    logic               w_info_rd;
    logic signed [31:0] w_rd_code;
    logic [15:0]        w_rd_pid;
    t_step              w_step;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    assign w_kind_idx = (r_state == S_SCAN) ? r_cur : r_item.signo;
    assign w_rd_idx   = (r_state == S_SCAN) ? r_cur : r_item.signo;

    spd_act_tbl u_act_tbl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (w_act_wr),
        .i_wr_idx     (r_item.signo),
        .i_wr_kind    (r_item.disposition),
        .i_wr_handler (r_item.handler_addr),
        .i_wr_restorer(r_item.restorer_addr),
        .i_wr_mask    (r_item.mask_value),
        .i_kind_idx   (w_kind_idx),
        .o_kind       (w_kind),
        .i_rd_en      (w_act_rd),
        .i_rd_idx     (w_rd_idx),
        .o_rd_handler (w_rd_handler),
        .o_rd_restorer(w_rd_restorer),
        .o_rd_mask    (w_rd_mask)
    );

    spd_info_tbl u_info_tbl (
        .i_clk    (i_clk),
        .i_wr_en  (w_info_wr),
        .i_wr_idx (r_item.signo),
        .i_wr_code(r_item.code),
        .i_wr_pid (r_item.sender_pid),
        .i_rd_en  (w_info_rd),
        .i_rd_idx (r_cur),
        .o_rd_code(w_rd_code),
        .o_rd_pid (w_rd_pid)
    );

    spd_scan_step u_scan_step (
        .i_sig    (r_cur),
        .i_pending(r_pending),
        .i_blocked(r_blocked),
        .i_kind   (w_kind),
        .o_step   (w_step)
    );

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_pending = r_pending;
        n_blocked = r_blocked;
        n_cur     = r_cur;
        w_act_wr  = 1'b0;
        w_act_rd  = 1'b0;
        w_info_wr = 1'b0;
        w_info_rd = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_OUT;
                case (r_act)
                    ACT_POST: begin
                        if (!sig_ok(r_item.signo)) begin
                            n_res.status = 1'b1;
                        end else if (int'(r_item.signo) == KILL_SIGNAL) begin
                            n_res.killed     = 1'b1;
                            n_res.kill_signo = r_item.signo;
                        end else begin
                            n_pending[r_item.signo] = 1'b1;
                            w_info_wr = 1'b1;
                        end
                    end
                    ACT_SETACT: begin
                        if (!sig_ok(r_item.signo)) begin
                            n_res.status = 1'b1;
                        end else begin
                            w_act_rd = 1'b1;
                            n_state  = S_LOOK;
                        end
                    end
                    ACT_MASK: begin
                        n_res.set_out = r_blocked;
                        case (r_item.mask_how)
                            HOW_BLOCK:   n_blocked = r_blocked | r_item.mask_value;
                            HOW_UNBLOCK: n_blocked = r_blocked & ~r_item.mask_value;
                            HOW_SETMASK: n_blocked = r_item.mask_value;
                            default:     n_blocked = r_blocked;
                        endcase
                    end
                    ACT_PENDING: begin
                        n_res.set_out = r_pending;
                    end
                    ACT_DELIVER: begin
                        n_cur   = SIG_W'(MIN_SIGNAL);
                        n_state = S_SCAN;
                    end
                    ACT_HRET: begin
                        n_blocked = r_item.mask_value;
                    end
                    default: begin
                        n_res.status = 1'b1;
                    end
                endcase
            end
            S_LOOK: begin
                n_res.target_addr     = w_rd_handler;
                n_res.return_addr     = w_rd_restorer;
                n_res.set_out         = w_rd_mask;
                n_res.old_disposition = w_kind;
                if (r_item.disposition == DISP_DEFAULT
                        || r_item.disposition == DISP_IGNORE
                        || r_item.disposition == DISP_HANDLER) begin
                    w_act_wr = 1'b1;
                end else begin
                    n_res.status = 1'b1;
                end
                n_state = S_OUT;
            end
            S_SCAN: begin
                if (w_step.clr_pend) begin
                    n_pending[r_cur] = 1'b0;
                end
                if (w_step.kill) begin
                    n_res.killed     = 1'b1;
                    n_res.kill_signo = r_cur;
                end
                if (w_step.hit) begin
                    // pull addresses, mask and sender info of this signal
                    n_res.delivered     = 1'b1;
                    n_res.deliver_signo = r_cur;
                    n_res.set_out       = r_blocked;
                    w_act_rd  = 1'b1;
                    w_info_rd = 1'b1;
                    n_state   = S_FETCH;
                end else if (int'(r_cur) >= SCAN_TOP) begin
                    n_state = S_OUT;
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            S_FETCH: begin
                n_res.target_addr = w_rd_handler;
                n_res.return_addr = w_rd_restorer;
                n_res.info_code   = w_rd_code;
                n_res.info_pid    = w_rd_pid;
                n_blocked = r_blocked | w_rd_mask | (32'd1 << r_res.deliver_signo);
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= '0;
            r_blocked <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_blocked <= n_blocked;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= t_item'(s_axis_tdata[ITEM_W-1:0]);
            r_act  <= s_axis_tuser;
        end
        if (w_load) begin
            r_m_data <= r_res;
        end
        r_res <= n_res;
        r_cur <= n_cur;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, r_m_data};

    // the kill signal is never left pending
    a_no_kill_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending[KILL_SIGNAL])
        else $error("kill signal found pending");

    // the scan cursor stays inside the scanned signal range
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (int'(r_cur) >= MIN_SIGNAL && int'(r_cur) <= SCAN_TOP))
        else $error("scan cursor out of range");

    // a fetch only follows a handler hit in the scan
    a_fetch_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> ($past(r_state) == S_SCAN && r_res.delivered))
        else $error("fetch without a handler hit");

    // a result is loaded only once per accepted operation
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE))
        else $error("result load did not return to idle");

endmodule

// ===== tb/signal_pending_dispatcher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signal_pending_dispatcher_tb - self-checking bench for the signal unit
// Drives post, set action, mask change, pending read, deliver, handler
// return and bad operation codes over the input stream, predicts every reply
// with a behavioral copy of the pending/blocked sets and the action table,
// and checks each reply field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module signal_pending_dispatcher_tb;
    import spd_pkg::*;

    localparam logic [2:0] ACT_BAD_LO = 3'd6;
    localparam logic [2:0] ACT_BAD_HI = 3'd7;
    localparam logic [1:0] DISP_UNDEF = 2'd3;
    localparam logic [1:0] HOW_QUERY  = 2'd3;
    localparam int TAIL_CYCLES = 40;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // signo, code, sender_pid, disposition, handler_addr, restorer_addr,
    // mask_value, mask_how, zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // action
    logic [ACT_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status, killed, kill_signo, delivered, deliver_signo, target_addr,
    // return_addr, info_code, info_pid, set_out, old_disposition, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    signal_pending_dispatcher i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow of the signal unit state
    logic [31:0] sig_pending;
    logic [31:0] sig_blocked;
    logic [1:0]  act_kind     [NUM_SIG];
    logic [63:0] act_handler  [NUM_SIG];
    logic [63:0] act_restorer [NUM_SIG];
    logic [31:0] act_mask     [NUM_SIG];
    logic [31:0] info_code_mem[NUM_SIG];
    logic [15:0] info_pid_mem [NUM_SIG];
    logic        last_delivered;
    logic [31:0] last_saved_mask;

    t_result signal_replies[$];

    int tx_idle_pct = 37;
    int rx_idle_pct = 84;
    int rx_hold     = 0;
    int n_errors    = 0;
    int n_ops       = 0;
    int n_replies   = 0;
    int n_entries   = 0;
    int n_kills     = 0;
    int n_rejects   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signo_in_range(input logic [SIG_W-1:0] s);
        return (s >= MIN_SIGNAL) && (s <= MAX_SIGNAL);
    endfunction

    // applies one operation to the shadow state and returns the reply it gives
    function automatic t_result signal_unit_step(input logic [2:0] act, input t_item it);
        t_result r;
        int      s;
        logic    found;
        r = '0;
        found = 1'b0;
        case (act)
            ACT_POST: begin
                if (!signo_in_range(it.signo)) begin
                    r.status = 1'b1;
                end else if (it.signo == KILL_SIGNAL) begin
                    r.killed = 1'b1;
                    r.kill_signo = it.signo;
                end else begin
                    sig_pending[it.signo] = 1'b1;
                    info_code_mem[it.signo] = it.code;
                    info_pid_mem[it.signo] = it.sender_pid;
                end
            end
            ACT_SETACT: begin
                if (!signo_in_range(it.signo)) begin
                    r.status = 1'b1;
                end else begin
                    r.target_addr = act_handler[it.signo];
                    r.return_addr = act_restorer[it.signo];
                    r.set_out = act_mask[it.signo];
                    r.old_disposition = act_kind[it.signo];
                    // an undefined kind still reports the old action
                    if (it.disposition > DISP_HANDLER) begin
                        r.status = 1'b1;
                    end else begin
                        act_kind[it.signo] = it.disposition;
                        act_handler[it.signo] = it.handler_addr;
                        act_restorer[it.signo] = it.restorer_addr;
                        act_mask[it.signo] = it.mask_value;
                    end
                end
            end
            ACT_MASK: begin
                r.set_out = sig_blocked;
                case (it.mask_how)
                    HOW_BLOCK:   sig_blocked = sig_blocked | it.mask_value;
                    HOW_UNBLOCK: sig_blocked = sig_blocked & ~it.mask_value;
                    HOW_SETMASK: sig_blocked = it.mask_value;
                    default: ;
                endcase
            end
            ACT_PENDING: r.set_out = sig_pending;
            ACT_DELIVER: begin
                last_delivered = 1'b0;
                for (s = MIN_SIGNAL; s <= SCAN_TOP && !found; s++) begin
                    if (sig_pending[s]) begin
                        // kill and stop cannot be blocked
                        if (s == KILL_SIGNAL || s == STOP_SIGNAL) begin
                            sig_pending[s] = 1'b0;
                            r.killed = 1'b1;
                            r.kill_signo = s[SIG_W-1:0];
                        end else if (!sig_blocked[s]) begin
                            sig_pending[s] = 1'b0;
                            if (act_kind[s] == DISP_HANDLER) begin
                                found = 1'b1;
                                r.delivered = 1'b1;
                                r.deliver_signo = s[SIG_W-1:0];
                                r.target_addr = act_handler[s];
                                r.return_addr = act_restorer[s];
                                r.info_code = info_code_mem[s];
                                r.info_pid = info_pid_mem[s];
                                r.set_out = sig_blocked;
                                sig_blocked = sig_blocked | act_mask[s] | (32'd1 << s);
                                last_delivered = 1'b1;
                                last_saved_mask = r.set_out;
                            end else if (act_kind[s] != DISP_IGNORE) begin
                                r.killed = 1'b1;
                                r.kill_signo = s[SIG_W-1:0];
                            end
                        end
                    end
                end
            end
            ACT_HRET: sig_blocked = it.mask_value;
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sparse_mask();
        return $urandom & $urandom & $urandom;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.signo = SIG_W'($urandom_range(NUM_SIG - 1));
        it.code = $urandom;
        it.sender_pid = 16'($urandom);
        it.disposition = 2'($urandom_range(3));
        it.handler_addr = {$urandom, $urandom};
        it.restorer_addr = {$urandom, $urandom};
        it.mask_value = ($urandom_range(3) == 0) ? $urandom : sparse_mask();
        it.mask_how = 2'($urandom_range(3));
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("reply %0d %s got %0h expected %0h",
                                      n_replies, name, got, want));
    endtask

    task automatic check_reply(input t_result got);
        t_result want;
        if (signal_replies.size() == 0) begin
            report_mismatch("reply with nothing outstanding");
        end else begin
            want = signal_replies.pop_front();
            cmp_field("status", 64'(got.status), 64'(want.status));
            cmp_field("killed", 64'(got.killed), 64'(want.killed));
            cmp_field("kill_signo", 64'(got.kill_signo), 64'(want.kill_signo));
            cmp_field("delivered", 64'(got.delivered), 64'(want.delivered));
            cmp_field("deliver_signo", 64'(got.deliver_signo), 64'(want.deliver_signo));
            cmp_field("target_addr", got.target_addr, want.target_addr);
            cmp_field("return_addr", got.return_addr, want.return_addr);
            cmp_field("info_code", 64'(got.info_code), 64'(want.info_code));
            cmp_field("info_pid", 64'(got.info_pid), 64'(want.info_pid));
            cmp_field("set_out", 64'(got.set_out), 64'(want.set_out));
            cmp_field("old_disposition", 64'(got.old_disposition),
                      64'(want.old_disposition));
        end
        n_replies++;
    endtask

    // reply side: random stalls plus a counted long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_reply(t_result'(m_axis_tdata[RES_W-1:0]));
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // offers one operation and waits for its transfer; tvalid stays high so
    // the next call can follow without a bubble
    task automatic send_op(input logic [2:0] act, input t_item it);
        t_result want;
        logic    idled;
        idled = 1'b0;
        while ($urandom_range(99) < tx_idle_pct) begin
            if (!idled)
                s_axis_tvalid <= 1'b0;
            idled = 1'b1;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {{(IN_DATA_W - ITEM_W){1'b0}}, it};
        do @(posedge i_clk); while (!s_axis_tready);
        want = signal_unit_step(act, it);
        signal_replies.push_back(want);
        n_ops++;
        if (want.delivered)
            n_entries++;
        if (want.killed)
            n_kills++;
        if (want.status)
            n_rejects++;
    endtask

    task automatic post_sig(input logic [SIG_W-1:0] signo, input logic [31:0] code,
                            input logic [15:0] pid);
        t_item it;
        it = rand_item();
        it.signo = signo;
        it.code = code;
        it.sender_pid = pid;
        send_op(ACT_POST, it);
    endtask

    task automatic set_act(input logic [SIG_W-1:0] signo, input logic [1:0] disp,
                           input logic [63:0] haddr, input logic [63:0] raddr,
                           input logic [31:0] mask);
        t_item it;
        it = rand_item();
        it.signo = signo;
        it.disposition = disp;
        it.handler_addr = haddr;
        it.restorer_addr = raddr;
        it.mask_value = mask;
        send_op(ACT_SETACT, it);
    endtask

    task automatic change_mask(input logic [1:0] how, input logic [31:0] mask);
        t_item it;
        it = rand_item();
        it.mask_how = how;
        it.mask_value = mask;
        send_op(ACT_MASK, it);
    endtask

    task automatic handler_return(input logic [31:0] mask);
        t_item it;
        it = rand_item();
        it.mask_value = mask;
        send_op(ACT_HRET, it);
    endtask

    task automatic plain_op(input logic [2:0] act);
        send_op(act, rand_item());
    endtask

    task automatic test_bad_requests();
        post_sig(5'd0, $urandom, 16'($urandom));
        set_act(5'd0, DISP_HANDLER, '1, '1, '1);
        plain_op(ACT_BAD_LO);
        set_act(5'd4, DISP_UNDEF, '1, '1, '1);
    endtask

    task automatic test_kill_and_stop();
        post_sig(SIG_W'(KILL_SIGNAL), 32'h8000_0000, 16'hffff);
        change_mask(HOW_SETMASK, '1);
        post_sig(SIG_W'(STOP_SIGNAL), 32'h7fff_ffff, 16'h0000);
        post_sig(5'd12, 32'h0000_0000, 16'h1234);
        plain_op(ACT_DELIVER);
        // 12 is blocked and must stay pending
        plain_op(ACT_DELIVER);
        change_mask(HOW_QUERY, $urandom);
        change_mask(HOW_UNBLOCK, 32'hffff_0000);
        change_mask(HOW_SETMASK, '0);
    endtask

    task automatic test_scan_order();
        set_act(5'd5, DISP_HANDLER, '1, '0, 32'h0000_0101);
        set_act(SIG_W'(MAX_SIGNAL), DISP_HANDLER, '0, '1, '1);
        set_act(5'd7, DISP_IGNORE, 64'($urandom), 64'($urandom), $urandom);
        post_sig(5'd3, $urandom, 16'($urandom));
        post_sig(5'd7, $urandom, 16'($urandom));
        post_sig(5'd5, 32'h8000_0000, 16'h0000);
        post_sig(SIG_W'(MAX_SIGNAL), 32'h7fff_ffff, 16'hffff);
        post_sig(SIG_W'(STOP_SIGNAL), $urandom, 16'($urandom));
        plain_op(ACT_PENDING);
        // default 3 terminates before handler 5 is taken
        plain_op(ACT_DELIVER);
        // ignored 7, default 12, stop, then handler 31
        plain_op(ACT_DELIVER);
        handler_return('0);
    endtask

    // long reply hold-off while operations keep coming
    task automatic test_backpressure();
        int i;
        tx_idle_pct = 0;
        rx_hold <= 250;
        for (i = 0; i < 20; i++) begin
            if (i % 3 == 2)
                plain_op(ACT_PENDING);
            else
                post_sig(SIG_W'($urandom_range(MAX_SIGNAL, MIN_SIGNAL)), $urandom,
                         16'($urandom));
        end
    endtask

    // typical life cycle: install, post, deliver, return from the handler
    task automatic run_handler_episode(inout int left);
        logic [SIG_W-1:0] sig;
        int               n_post;
        sig = SIG_W'($urandom_range(MAX_SIGNAL, MIN_SIGNAL));
        if ($urandom_range(1)) begin
            set_act(sig, ($urandom_range(3) == 0) ? 2'($urandom_range(1)) : DISP_HANDLER,
                    {$urandom, $urandom}, {$urandom, $urandom}, sparse_mask());
            left--;
        end
        n_post = $urandom_range(3, 1);
        repeat (n_post) begin
            post_sig(($urandom_range(2) != 0) ? sig : 5'($urandom_range(NUM_SIG - 1)),
                     $urandom, 16'($urandom));
            left--;
        end
        plain_op(ACT_DELIVER);
        left--;
        if (last_delivered) begin
            handler_return(last_saved_mask);
            left--;
        end else if ($urandom_range(1)) begin
            change_mask(HOW_UNBLOCK, $urandom);
            left--;
        end
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int   left;
        logic [2:0] act;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(99) < 55) begin
                run_handler_episode(left);
            end else begin
                if ($urandom_range(19) == 0)
                    act = 3'($urandom_range(ACT_BAD_HI, ACT_BAD_LO));
                else
                    act = 3'($urandom_range(ACT_HRET, ACT_POST));
                plain_op(act);
                left--;
            end
        end
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (signal_replies.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        sig_pending = '0;
        sig_blocked = '0;
        last_delivered = 1'b0;
        last_saved_mask = '0;
        for (int k = 0; k < NUM_SIG; k++) begin
            act_kind[k] = DISP_DEFAULT;
            act_handler[k] = '0;
            act_restorer[k] = '0;
            act_mask[k] = '0;
            info_code_mem[k] = '0;
            info_pid_mem[k] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bad_requests();
        test_kill_and_stop();
        test_scan_order();
        test_backpressure();
        test_random_traffic(370, 37, 84);
        test_random_traffic(370, 84, 37);
        test_random_traffic(370, 0, 0);
        drain_replies();

        $display("covered %0d operations and %0d replies, all action codes and mask modes",
                 n_ops, n_replies);
        $display("%0d handler entries, %0d terminations, %0d rejected requests",
                 n_entries, n_kills, n_rejects);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #800_000;
        $display("timeout with %0d replies outstanding", signal_replies.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
